[hdl/slid_pkg.sv]
// Shared types, codes and constants for the sorted list block.
`default_nettype none

package slid_pkg;

  localparam int CAPACITY_DEF = 16;

  typedef enum logic [2:0] {
    ACT_CLEAR  = 3'd0,
    ACT_APPEND = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_INSERT = 3'd3,
    ACT_READ   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DEL  = 2'd2,
    S_DONE = 2'd3
  } state_t;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
    logic [3:0]         index;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         entry_count;
    logic               is_sorted;
    logic signed [31:0] read_value;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic del_step;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic act_del;
    logic any_match;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[hdl/slid_ctrl.sv]
// Sequencer for the sorted list block: accepts a request, runs it, emits the result.
`default_nettype none

module slid_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire slid_pkg::sts_t sts,
  output slid_pkg::cmd_t     cmd
);

  slid_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slid_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_stall     = 1'b1;
    unique case (state_r)
      slid_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = slid_pkg::S_EXEC;
        end
      end
      slid_pkg::S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.act_del ? slid_pkg::S_DEL : slid_pkg::S_DONE;
      end
      slid_pkg::S_DEL: begin
        // remove one occurrence per cycle until none is left
        cmd.del_step = 1'b1;
        if (!sts.any_match) begin
          state_nxt = slid_pkg::S_DONE;
        end
      end
      slid_pkg::S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = slid_pkg::S_IDLE;
        end
      end
      default: state_nxt = slid_pkg::S_IDLE;
    endcase
  end

  a_del_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slid_pkg::S_DEL) |->
      ($past(state_r) == slid_pkg::S_EXEC || $past(state_r) == slid_pkg::S_DEL))
    else $error("delete step entered from an unexpected state");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (sts.out_free && state_r == slid_pkg::S_DONE))
    else $error("result emitted while output register busy");

endmodule

`default_nettype wire

[hdl/slid_dp.sv]
// Datapath of the sorted list block: entry cells, count, status and the result register.
`default_nettype none

module slid_dp #(
  parameter int CAPACITY = slid_pkg::CAPACITY_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire slid_pkg::req_t in_data,
  input  wire slid_pkg::cmd_t cmd,
  output slid_pkg::sts_t      sts,
  output logic                out_valid,
  input  wire logic           out_stall,
  output slid_pkg::rsp_t      out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  slid_pkg::req_t         req_r;
  logic signed [31:0]     cell_r   [CAPACITY];
  logic signed [31:0]     cell_nxt [CAPACITY];
  logic signed [31:0]     cell_up  [CAPACITY];  // neighbor above, for closing a gap
  logic signed [31:0]     cell_dn  [CAPACITY];  // neighbor below, for opening a gap
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [1:0]             status_r, status_nxt;
  logic signed [31:0]     rd_r, rd_nxt;
  logic                   out_valid_r;
  slid_pkg::rsp_t         out_data_r;

  logic [CAPACITY-1:0]    vld, lv, match, pre;
  logic                   sorted, full, bad_idx, any_match;
  logic signed [31:0]     rd_sel;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_nb
    if (g < CAPACITY - 1) begin : g_up
      assign cell_up[g] = cell_r[g+1];
    end else begin : g_top
      assign cell_up[g] = cell_r[g];
    end
    if (g > 0) begin : g_dn
      assign cell_dn[g] = cell_r[g-1];
    end else begin : g_bot
      assign cell_dn[g] = req_r.value;
    end
  end

  // per-cell compares, all in parallel
  always_comb begin
    sorted = 1'b1;
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      vld[i]   = count_r > CNT_W'(i);
      lv[i]    = vld[i] && (cell_r[i] < $signed(req_r.value));
      match[i] = vld[i] && (cell_r[i] == req_r.value);
      pre[i]   = (i > 0) ? (pre[(i > 0) ? i - 1 : 0] | match[i]) : match[i];
      if (i > 0 && vld[i] && (cell_r[i] < cell_dn[i])) begin
        sorted = 1'b0;
      end
      if (int'(req_r.index) == i) begin
        rd_sel = cell_r[i];
      end
    end
    any_match = |match;
    full      = count_r >= CNT_W'(CAPACITY);
    bad_idx   = int'(req_r.index) >= int'(count_r);
  end

  always_comb begin
    cell_nxt   = cell_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    rd_nxt     = rd_r;
    if (cmd.exec) begin
      status_nxt = slid_pkg::ST_OK;
      rd_nxt     = '0;
      unique case (req_r.action)
        slid_pkg::ACT_CLEAR: begin
          count_nxt = '0;
        end
        slid_pkg::ACT_APPEND: begin
          if (full) begin
            status_nxt = slid_pkg::ST_FULL;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (count_r == CNT_W'(i)) cell_nxt[i] = req_r.value;
            end
            count_nxt = count_r + CNT_W'(1);
          end
        end
        slid_pkg::ACT_DELETE: begin
          status_nxt = slid_pkg::ST_NOT_FOUND;
        end
        slid_pkg::ACT_INSERT: begin
          if (full) begin
            status_nxt = slid_pkg::ST_FULL;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (sorted) begin
                // keep smaller entries, drop value at the boundary, shift the rest up
                if (lv[i]) begin
                  cell_nxt[i] = cell_r[i];
                end else if (i == 0 || lv[(i > 0) ? i - 1 : 0]) begin
                  cell_nxt[i] = req_r.value;
                end else if (vld[(i > 0) ? i - 1 : 0]) begin
                  cell_nxt[i] = cell_dn[i];
                end
              end else if (count_r == CNT_W'(i)) begin
                cell_nxt[i] = req_r.value;
              end
            end
            count_nxt = count_r + CNT_W'(1);
          end
        end
        slid_pkg::ACT_READ: begin
          if (bad_idx) begin
            status_nxt = slid_pkg::ST_BAD_INDEX;
          end else begin
            rd_nxt = rd_sel;
          end
        end
        default: begin
        end
      endcase
    end else if (cmd.del_step && any_match) begin
      // close the gap at the first matching entry
      for (int i = 0; i < CAPACITY; i++) begin
        if (pre[i]) cell_nxt[i] = cell_up[i];
      end
      count_nxt  = count_r - CNT_W'(1);
      status_nxt = slid_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
    cell_r   <= cell_nxt;
    status_r <= status_nxt;
    rd_r     <= rd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.status      <= status_r;
      out_data_r.entry_count <= 5'(count_r);
      out_data_r.is_sorted   <= sorted;
      out_data_r.read_value  <= rd_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign sts.act_del   = req_r.action == slid_pkg::ACT_DELETE;
  assign sts.any_match = any_match;
  assign sts.out_free  = !out_valid_r || !out_stall;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.del_step && any_match) |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("delete step did not drop one entry");

  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != slid_pkg::ST_OK) |-> (out_data_r.read_value == '0))
    else $error("read value nonzero on failed request");

endmodule

`default_nettype wire

[hdl/sorted_list_insert_delete.sv]
// Top level of the sorted list block: sequencer plus entry datapath.
//
// Holds a packed list of up to CAPACITY signed 32-bit entries with a count.
// Input channel (in_valid, in_stall, in_data) carries one request: clear,
// append, delete every occurrence of a value, insert (ascending position
// when the list is non-decreasing, else appended) or read an entry.
// Each request yields one result on (out_valid, out_stall, out_data):
// status, entry count, sorted flag and the read value.
// The request is registered on acceptance and run in the execute state;
// its result is loaded into the output register from the done state. A
// delete passes through the delete state in between, where the entry cells
// close one gap per cycle and are searched again before finishing.
// One request is worked on at a time; in_stall is high from acceptance
// until the result is loaded into the output register.
// A stalled result holds in the output register; the next request may be
// accepted meanwhile but waits before its own result is loaded.
// Reset empties the list and drops any pending result; entry contents
// are not cleared.
`default_nettype none

module sorted_list_insert_delete #(
  parameter int CAPACITY = slid_pkg::CAPACITY_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire slid_pkg::req_t in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output slid_pkg::rsp_t      out_data
);

  slid_pkg::cmd_t cmd;
  slid_pkg::sts_t sts;

  slid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  slid_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[tb/tb_sorted_list_insert_delete.sv]
// Self-checking testbench for the sorted list block: directed table, random requests, shadow list.
`default_nettype none

module tb_sorted_list_insert_delete;

  localparam int CAP = slid_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 650;
  localparam int CALM_TAIL = 80;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_OFF_CYCLES = 90;
  localparam int HOLD_OFF_AFTER = 150;
  localparam logic [2:0] ACT_RSVD_LO = 3'd5;
  localparam logic [2:0] ACT_RSVD_HI = 3'd7;
  localparam logic signed [31:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic signed [31:0] VAL_MIN = 32'h8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  slid_pkg::req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  slid_pkg::rsp_t out_data;

  sorted_list_insert_delete i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the list
  logic signed [31:0] shadow_entries [CAP];
  int                 shadow_count = 0;

  slid_pkg::rsp_t list_results_q [$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   requests_sent = 0;
  int   action_hits [8];
  int   status_hits [4];
  bit   quiet = 1'b0;

  typedef struct {
    logic [2:0]         action;
    logic signed [31:0] value;
    logic [3:0]         index;
    int                 reps;
    bit                 typed;
    logic [1:0]         st;
    int                 cnt;
    bit                 srt;
    logic signed [31:0] rv;
  } step_row_t;

  // typed rows give the expected result; the rest use the shadow list
  step_row_t plan [20] = '{
    '{slid_pkg::ACT_READ,   0,       4'd0,  1, 1, slid_pkg::ST_BAD_INDEX, 0,  1, 0},
    '{slid_pkg::ACT_DELETE, 0,       4'd0,  1, 1, slid_pkg::ST_NOT_FOUND, 0,  1, 0},
    '{ACT_RSVD_HI,          0,       4'd9,  1, 1, slid_pkg::ST_OK,        0,  1, 0},
    '{slid_pkg::ACT_INSERT, VAL_MAX, 4'd0,  1, 1, slid_pkg::ST_OK,        1,  1, 0},
    '{slid_pkg::ACT_INSERT, VAL_MIN, 4'd0,  1, 1, slid_pkg::ST_OK,        2,  1, 0},
    '{slid_pkg::ACT_INSERT, 0,       4'd0,  1, 0, slid_pkg::ST_OK,        0,  0, 0},
    '{slid_pkg::ACT_INSERT, 0,       4'd0,  1, 0, slid_pkg::ST_OK,        0,  0, 0},
    '{slid_pkg::ACT_READ,   0,       4'd0,  1, 1, slid_pkg::ST_OK,        4,  1, VAL_MIN},
    '{slid_pkg::ACT_READ,   0,       4'd4,  1, 1, slid_pkg::ST_BAD_INDEX, 4,  1, 0},
    '{slid_pkg::ACT_INSERT, 1000,    4'd0, 12, 0, slid_pkg::ST_OK,        0,  0, 0},
    '{slid_pkg::ACT_APPEND, 7,       4'd0,  1, 1, slid_pkg::ST_FULL,      16, 1, 0},
    '{slid_pkg::ACT_INSERT, 7,       4'd0,  1, 1, slid_pkg::ST_FULL,      16, 1, 0},
    '{slid_pkg::ACT_READ,   0,       4'd15, 1, 1, slid_pkg::ST_OK,        16, 1, VAL_MAX},
    '{slid_pkg::ACT_DELETE, 0,       4'd0,  1, 0, slid_pkg::ST_OK,        0,  0, 0},
    '{slid_pkg::ACT_APPEND, -5,      4'd0,  1, 0, slid_pkg::ST_OK,        0,  0, 0},
    '{slid_pkg::ACT_INSERT, 3,       4'd0,  1, 0, slid_pkg::ST_OK,        0,  0, 0},
    '{slid_pkg::ACT_DELETE, 12345,   4'd0,  1, 0, slid_pkg::ST_OK,        0,  0, 0},
    '{ACT_RSVD_LO,          -1,      4'd15, 1, 0, slid_pkg::ST_OK,        0,  0, 0},
    '{slid_pkg::ACT_CLEAR,  -1,      4'd15, 1, 1, slid_pkg::ST_OK,        0,  1, 0},
    '{slid_pkg::ACT_READ,   0,       4'd15, 1, 1, slid_pkg::ST_BAD_INDEX, 0,  1, 0}
  };

  function automatic bit list_is_sorted();
    for (int i = 1; i < shadow_count; i++)
      if (shadow_entries[i] < shadow_entries[i - 1]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic slid_pkg::rsp_t apply_list_action(slid_pkg::req_t r);
    slid_pkg::rsp_t res;
    int   w;
    int   pos;
    res = '0;
    res.status = slid_pkg::ST_OK;
    case (r.action)
      slid_pkg::ACT_CLEAR: shadow_count = 0;
      slid_pkg::ACT_APPEND: begin
        if (shadow_count >= CAP) begin
          res.status = slid_pkg::ST_FULL;
        end else begin
          shadow_entries[shadow_count] = r.value;
          shadow_count++;
        end
      end
      slid_pkg::ACT_DELETE: begin
        w = 0;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_entries[i] != r.value) begin
            shadow_entries[w] = shadow_entries[i];
            w++;
          end
        end
        if (w == shadow_count) res.status = slid_pkg::ST_NOT_FOUND;
        shadow_count = w;
      end
      slid_pkg::ACT_INSERT: begin
        if (shadow_count >= CAP) begin
          res.status = slid_pkg::ST_FULL;
        end else begin
          // unsorted list: fall back to append
          pos = shadow_count;
          if (list_is_sorted()) begin
            pos = 0;
            while (pos < shadow_count && shadow_entries[pos] < r.value) pos++;
            for (int i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i - 1];
          end
          shadow_entries[pos] = r.value;
          shadow_count++;
        end
      end
      slid_pkg::ACT_READ: begin
        if (r.index >= shadow_count) res.status = slid_pkg::ST_BAD_INDEX;
        else res.read_value = shadow_entries[r.index];
      end
      default: ;
    endcase
    res.entry_count = shadow_count[4:0];
    res.is_sorted = list_is_sorted();
    return res;
  endfunction

  task automatic push_request(input slid_pkg::req_t r, input bit typed,
                              input slid_pkg::rsp_t typed_rsp);
    int   gap;
    slid_pkg::rsp_t predicted;
    gap = (!quiet && $urandom_range(3) == 0) ? $urandom_range(17, 1) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    predicted = apply_list_action(r);
    list_results_q.push_back(typed ? typed_rsp : predicted);
    requests_sent++;
    action_hits[r.action]++;
  endtask

  task automatic check_field(input string label, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
    end
  endtask

  always @(posedge clk) begin
    slid_pkg::rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      status_hits[out_data.status]++;
      if (list_results_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, got %0h", $time, out_data);
      end else begin
        want = list_results_q.pop_front();
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("entry_count", 32'(want.entry_count), 32'(out_data.entry_count));
        check_field("is_sorted", 32'(want.is_sorted), 32'(out_data.is_sorted));
        check_field("read_value", want.read_value, out_data.read_value);
      end
    end
  end

  // result side: random stall bursts plus one long hold-off
  initial begin
    int stall_left;
    bit held_off;
    stall_left = 0;
    held_off = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0) begin
        if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
          stall_left = HOLD_OFF_CYCLES;
          held_off = 1'b1;
        end else if (!quiet && $urandom_range(4) == 0) begin
          stall_left = $urandom_range(17, 1);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("[sorted_list_insert_delete] ERROR");
    $finish;
  end

  initial begin
    slid_pkg::req_t r;
    slid_pkg::rsp_t typed_rsp;
    int   pick;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[row]) begin
      for (int k = 0; k < plan[row].reps; k++) begin
        r.action = plan[row].action;
        r.value = plan[row].value + k;
        r.index = plan[row].index;
        typed_rsp.status = plan[row].st;
        typed_rsp.entry_count = plan[row].cnt[4:0];
        typed_rsp.is_sorted = plan[row].srt;
        typed_rsp.read_value = plan[row].rv;
        push_request(r, plan[row].typed, typed_rsp);
      end
    end

    typed_rsp = '0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= RANDOM_ITEMS - CALM_TAIL) || ((n / 60) % 4 == 3);
      pick = $urandom_range(99);
      case ($urandom_range(9))
        0:       r.value = VAL_MAX;
        1:       r.value = VAL_MIN;
        2, 3, 4: r.value = $signed($urandom_range(8)) - 4;
        default: r.value = $urandom;
      endcase
      r.index = 4'($urandom_range(15));
      if (pick < 3) begin
        r.action = slid_pkg::ACT_CLEAR;
      end else if (pick < 5) begin
        r.action = 3'($urandom_range(ACT_RSVD_HI, ACT_RSVD_LO));
      end else if (pick < 42) begin
        r.action = slid_pkg::ACT_INSERT;
      end else if (pick < 54) begin
        r.action = slid_pkg::ACT_APPEND;
      end else if (pick < 78) begin
        r.action = slid_pkg::ACT_DELETE;
        // mostly hit a held value
        if (shadow_count > 0 && $urandom_range(3) != 0)
          r.value = shadow_entries[$urandom_range(shadow_count - 1)];
      end else begin
        r.action = slid_pkg::ACT_READ;
        if (shadow_count > 0 && $urandom_range(3) != 0)
          r.index = 4'($urandom_range(shadow_count - 1));
      end
      push_request(r, 1'b0, typed_rsp);
    end
    in_valid <= 1'b0;

    while (list_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (list_results_q.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, list_results_q.size());
    end

    $display("Ran %0d requests (clear %0d, append %0d, delete %0d, insert %0d, read %0d,",
             requests_sent, action_hits[slid_pkg::ACT_CLEAR], action_hits[slid_pkg::ACT_APPEND],
             action_hits[slid_pkg::ACT_DELETE], action_hits[slid_pkg::ACT_INSERT],
             action_hits[slid_pkg::ACT_READ]);
    $display("  undefined %0d); checked %0d results: %0d ok, %0d full, %0d not found, %0d bad index",
             action_hits[5] + action_hits[6] + action_hits[7],
             results_seen, status_hits[slid_pkg::ST_OK], status_hits[slid_pkg::ST_FULL],
             status_hits[slid_pkg::ST_NOT_FOUND], status_hits[slid_pkg::ST_BAD_INDEX]);
    if (mismatches == 0) begin
      $display("[sorted_list_insert_delete] OK");
    end else begin
      $display("[sorted_list_insert_delete] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
